FILE: src/pg3d_pkg.sv
// Shared types and codes for the 3D gradient texture pipeline.
package pg3d_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int MODE_W      = 4;
    localparam int REP_W       = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MODE   = 2'd0,
        CFG_REPEAT = 2'd1,
        CFG_SMOOTH = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        GRP_X      = 3'd0,
        GRP_Y      = 3'd1,
        GRP_Z      = 3'd2,
        GRP_SPHERE = 3'd3,
        GRP_CYL_X  = 3'd4,
        GRP_CYL_Y  = 3'd5,
        GRP_CYL_Z  = 3'd6,
        GRP_BOX    = 3'd7
    } grp_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [REP_W-1:0]  rep_count;
        logic              smooth;
    } cfg_t;

endpackage

FILE: src/procedural_gradient_3d.sv
// Top level of the 3D gradient texture pipeline with its configuration registers.
//
// One point (coord_x, coord_y, coord_z) enters per clock and one gradient_value
// leaves per clock while a stalled output does not hold the pipeline. The path runs
// through two front-end stages, FRAC_BITS + 2 square-root stages that settle one root bit
// each, and four back-end stages for repeat, mirror/clamp and the two smoothstep
// products, the last of which is the output register. A stall on the output
// freezes the whole pipeline, and in_stall then follows it in the same cycle.
// Configuration registers are written through cfg_write/cfg_index/cfg_data and
// must only change while no transaction is in flight.
module procedural_gradient_3d
    import pg3d_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [FRAC_BITS:0]     coord_x,
    input  logic [FRAC_BITS:0]     coord_y,
    input  logic [FRAC_BITS:0]     coord_z,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [FRAC_BITS:0]     gradient_value
);

    localparam int VW     = FRAC_BITS + 1;
    localparam int NW     = 2 * FRAC_BITS + 4;
    localparam int QW     = FRAC_BITS + 2;
    localparam int SIDE_W = FRAC_BITS + 2;

    cfg_t              cfg_reg;
    logic              advance;

    logic              fr_valid;
    logic [NW-1:0]     fr_radicand;
    logic [VW-1:0]     fr_lin;
    logic              fr_rad;

    logic              sq_valid;
    logic [QW-1:0]     sq_root;
    logic [SIDE_W-1:0] sq_side;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode      <= '0;
            cfg_reg.rep_count <= REP_W'(1);
            cfg_reg.smooth    <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MODE:   cfg_reg.mode      <= cfg_data[MODE_W-1:0];
                CFG_REPEAT: cfg_reg.rep_count <= cfg_data[REP_W-1:0];
                CFG_SMOOTH: cfg_reg.smooth    <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;

    pg3d_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .coord_z   (coord_z),
        .out_valid (fr_valid),
        .radicand  (fr_radicand),
        .lin_value (fr_lin),
        .is_radius (fr_rad)
    );

    pg3d_isqrt #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (SIDE_W)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (fr_valid),
        .radicand  (fr_radicand),
        .side_in   ({fr_lin, fr_rad}),
        .out_valid (sq_valid),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    pg3d_shape #(
        .FRAC_BITS (FRAC_BITS)
    ) u_shape (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .cfg       (cfg_reg),
        .in_valid  (sq_valid),
        .root      (sq_root),
        .lin_value (sq_side[SIDE_W-1:1]),
        .is_radius (sq_side[0]),
        .out_valid (out_valid),
        .result    (gradient_value)
    );

endmodule

FILE: src/pg3d_front.sv
// Front end: coordinate saturation, centre offsets, squares and mode selection.
module pg3d_front
    import pg3d_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  cfg_t                     cfg,
    input  logic                     in_valid,
    input  logic [FRAC_BITS:0]       coord_x,
    input  logic [FRAC_BITS:0]       coord_y,
    input  logic [FRAC_BITS:0]       coord_z,
    output logic                     out_valid,
    output logic [2*FRAC_BITS+3:0]   radicand,
    output logic [FRAC_BITS:0]       lin_value,
    output logic                     is_radius
);

    localparam int VW = FRAC_BITS + 1;
    localparam int DW = FRAC_BITS;
    localparam int QW = 2 * FRAC_BITS;
    localparam int SW = 2 * FRAC_BITS + 2;
    localparam int NW = 2 * FRAC_BITS + 4;
    localparam logic [VW-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [VW-1:0] HALF = {2'b01, {(FRAC_BITS-1){1'b0}}};

    logic [VW-1:0] xs, ys, zs;
    logic [DW-1:0] dx, dy, dz;

    logic [VW-1:0] x_reg, y_reg, z_reg;
    logic [DW-1:0] dx_reg, dy_reg, dz_reg;
    logic [QW-1:0] sqx_reg, sqy_reg, sqz_reg;
    logic          v1_reg;

    logic [SW-1:0] sum_next;
    logic [VW-1:0] lin_next;
    logic          rad_next;
    logic [DW-1:0] max_xy, max_xyz;

    logic [NW-1:0] radicand_reg;
    logic [VW-1:0] lin_reg;
    logic          rad_reg;
    logic          v2_reg;

    assign xs = (coord_x > ONE) ? ONE : coord_x;
    assign ys = (coord_y > ONE) ? ONE : coord_y;
    assign zs = (coord_z > ONE) ? ONE : coord_z;

    assign dx = (xs >= HALF) ? DW'(xs - HALF) : DW'(HALF - xs);
    assign dy = (ys >= HALF) ? DW'(ys - HALF) : DW'(HALF - ys);
    assign dz = (zs >= HALF) ? DW'(zs - HALF) : DW'(HALF - zs);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg   <= xs;
            y_reg   <= ys;
            z_reg   <= zs;
            dx_reg  <= dx;
            dy_reg  <= dy;
            dz_reg  <= dz;
            sqx_reg <= QW'(dx) * QW'(dx);
            sqy_reg <= QW'(dy) * QW'(dy);
            sqz_reg <= QW'(dz) * QW'(dz);
        end
    end

    assign max_xy  = (dy_reg > dx_reg) ? dy_reg : dx_reg;
    assign max_xyz = (dz_reg > max_xy) ? dz_reg : max_xy;

    always_comb
    begin
        sum_next = '0;
        lin_next = '0;
        rad_next = 1'b0;
        unique case (grp_t'(cfg.mode[MODE_W-1:1]))
            GRP_X:      lin_next = x_reg;
            GRP_Y:      lin_next = y_reg;
            GRP_Z:      lin_next = z_reg;
            GRP_SPHERE:
            begin
                sum_next = SW'(sqx_reg) + SW'(sqy_reg) + SW'(sqz_reg);
                rad_next = 1'b1;
            end
            GRP_CYL_X:
            begin
                sum_next = SW'(sqy_reg) + SW'(sqz_reg);
                rad_next = 1'b1;
            end
            GRP_CYL_Y:
            begin
                sum_next = SW'(sqz_reg) + SW'(sqx_reg);
                rad_next = 1'b1;
            end
            GRP_CYL_Z:
            begin
                sum_next = SW'(sqx_reg) + SW'(sqy_reg);
                rad_next = 1'b1;
            end
            GRP_BOX:    lin_next = {max_xyz, 1'b0};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            radicand_reg <= {sum_next, 2'b00};
            lin_reg      <= lin_next;
            rad_reg      <= rad_next;
        end
    end

    assign out_valid = v2_reg;
    assign radicand  = radicand_reg;
    assign lin_value = lin_reg;
    assign is_radius = rad_reg;

endmodule

FILE: src/pg3d_isqrt.sv
// Pipelined integer square root, one result bit per stage, with side data.
module pg3d_isqrt
    import pg3d_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 18
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic                   in_valid,
    input  logic [2*FRAC_BITS+3:0] radicand,
    input  logic [SIDE_W-1:0]      side_in,
    output logic                   out_valid,
    output logic [FRAC_BITS+1:0]   root,
    output logic [SIDE_W-1:0]      side_out
);

    localparam int NW = 2 * FRAC_BITS + 4;
    localparam int NB = FRAC_BITS + 2;
    localparam int QW = FRAC_BITS + 2;
    localparam int RW = FRAC_BITS + 4;

    logic [NW-1:0]     st_n    [0:NB-1];
    logic [RW-1:0]     st_rem  [0:NB-1];
    logic [QW-1:0]     st_root [0:NB];
    logic [SIDE_W-1:0] st_side [0:NB];
    logic              st_valid[0:NB];

    assign st_n[0]     = radicand;
    assign st_rem[0]   = '0;
    assign st_root[0]  = '0;
    assign st_side[0]  = side_in;
    assign st_valid[0] = in_valid;

    for (genvar k = 0; k < NB; k++)
    begin : g_stage
        logic [RW+1:0] cur;
        logic [RW+1:0] trial;
        logic          take;
        logic [QW-1:0]     root_reg;
        logic [SIDE_W-1:0] side_reg;
        logic              valid_reg;

        assign cur   = {st_rem[k], st_n[k][NW-1 -: 2]};
        assign trial = (RW+2)'({st_root[k], 2'b01});
        assign take  = (cur >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg <= 1'b0;
            else if (advance)
                valid_reg <= st_valid[k];
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                root_reg <= {st_root[k][QW-2:0], take};
                side_reg <= st_side[k];
            end
        end

        assign st_root[k+1]  = root_reg;
        assign st_side[k+1]  = side_reg;
        assign st_valid[k+1] = valid_reg;

        if (k < NB - 1)
        begin : g_carry
            logic [NW-1:0] n_reg;
            logic [RW-1:0] rem_reg;

            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    n_reg   <= st_n[k] << 2;
                    rem_reg <= take ? RW'(cur - trial) : RW'(cur);
                end
            end

            assign st_n[k+1]   = n_reg;
            assign st_rem[k+1] = rem_reg;
        end
    end

    assign out_valid = st_valid[NB];
    assign root      = st_root[NB];
    assign side_out  = st_side[NB];

endmodule

FILE: src/pg3d_shape.sv
// Back end: repeat, mirror, clamp, smoothstep and the output register.
module pg3d_shape
    import pg3d_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  cfg_t                 cfg,
    input  logic                 in_valid,
    input  logic [FRAC_BITS+1:0] root,
    input  logic [FRAC_BITS:0]   lin_value,
    input  logic                 is_radius,
    output logic                 out_valid,
    output logic [FRAC_BITS:0]   result
);

    localparam int VW = FRAC_BITS + 1;
    localparam int RW = FRAC_BITS + 2;
    localparam int MW = FRAC_BITS + 3;
    localparam int PW = FRAC_BITS + 2 + REP_W;
    localparam int SQW = 2 * FRAC_BITS + 2;
    localparam int FW = FRAC_BITS + 2;
    localparam int SMW = 2 * FRAC_BITS + 3;
    localparam logic [VW-1:0] ONE    = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [RW-1:0] HALF   = {3'b001, {(FRAC_BITS-1){1'b0}}};
    localparam logic [MW-1:0] ONE_M  = {3'b001, {FRAC_BITS{1'b0}}};
    localparam logic [FW-1:0] THREE  = {2'b11, {FRAC_BITS{1'b0}}};

    logic [RW-1:0]  v_sel;
    logic [PW-1:0]  prod;
    logic [RW-1:0]  rep_next;
    logic [RW-1:0]  rep_reg;
    logic           va_reg;

    logic [RW-1:0]  diff;
    logic [MW-1:0]  mir;
    logic [VW-1:0]  clamp_next;
    logic [VW-1:0]  t_reg;
    logic           vb_reg;

    logic [SQW-1:0] sq;
    logic [VW-1:0]  t2_reg;
    logic [FW-1:0]  fac_reg;
    logic [VW-1:0]  tc_reg;
    logic           vc_reg;

    logic [SMW-1:0] smooth_prod;
    logic [VW-1:0]  result_reg;
    logic           vd_reg;

    assign v_sel    = is_radius ? root : RW'(lin_value);
    assign prod     = PW'(v_sel) * PW'(cfg.rep_count);
    assign rep_next = (cfg.rep_count != '0) ? RW'(prod[FRAC_BITS-1:0]) : v_sel;

    assign diff = (rep_reg >= HALF) ? (rep_reg - HALF) : (HALF - rep_reg);
    assign mir  = cfg.mode[0] ? {diff, 1'b0} : MW'(rep_reg);
    assign clamp_next = (mir > ONE_M) ? ONE : VW'(mir);

    assign sq = SQW'(t_reg) * SQW'(t_reg);

    assign smooth_prod = SMW'(t2_reg) * SMW'(fac_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else if (advance)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rep_reg    <= rep_next;
            t_reg      <= clamp_next;
            t2_reg     <= sq[2*FRAC_BITS:FRAC_BITS];
            fac_reg    <= THREE - {t_reg, 1'b0};
            tc_reg     <= t_reg;
            result_reg <= cfg.smooth ? smooth_prod[2*FRAC_BITS:FRAC_BITS] : tc_reg;
        end
    end

    assign out_valid = vd_reg;
    assign result    = result_reg;

endmodule
